@@ hw/rtl/hbp_pkg.sv @@
// Shared types and constants of the H-bridge PWM block with stall cutoff.
package hbp_pkg;

    localparam int PERIOD_W   = 16;
    localparam int LIMIT_W    = 16;
    localparam int DEADBAND_W = 7;
    localparam int FLOOR_W    = 15;
    localparam int CMD_W      = 16;
    localparam int SPEED_W    = 16;
    localparam int DUTY_W     = 8;
    localparam int COUNT_W    = 17;
    localparam int PCT_W      = 7;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Division by 100 is done as a multiply by ceil(2^30/100) and a shift of 30.
    // It is exact for every dividend below 2^30/76, which covers 65535*100.
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam int PK_W        = PERIOD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 16'd1000;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 16'd20000;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 7'd5;
    localparam logic [FLOOR_W-1:0]    FLOOR_RESET    = 15'd5;

    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 17'd131071;
    localparam logic [PCT_W-1:0]      FULL_PCT       = 7'd100;

    typedef enum logic [1:0] {
        REG_PERIOD   = 2'd0,
        REG_LIMIT    = 2'd1,
        REG_DEADBAND = 2'd2,
        REG_FLOOR    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PERIOD_W-1:0]   period;
        logic [PK_W-1:0]       period_k;   // period times the reciprocal of 100
        logic [LIMIT_W-1:0]    limit;
        logic [DEADBAND_W-1:0] deadband;
        logic [FLOOR_W-1:0]    speed_floor;
    } t_cfg;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic                     latched;
        logic signed [DUTY_W-1:0] left_duty;
        logic signed [DUTY_W-1:0] right_duty;
    } t_stall_next;

endpackage

@@ hw/rtl/hbp_regs.sv @@
// Configuration register file behind the APB-style port.
module hbp_regs
    import hbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = t_reg_idx'(i_paddr[3:2]);
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period      <= PERIOD_RESET;
            r_cfg.period_k    <= PK_W'(PERIOD_RESET) * PK_W'(RECIP_100);
            r_cfg.limit       <= LIMIT_RESET;
            r_cfg.deadband    <= DEADBAND_RESET;
            r_cfg.speed_floor <= FLOOR_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PERIOD: begin
                    r_cfg.period   <= i_pwdata[PERIOD_W-1:0];
                    r_cfg.period_k <= PK_W'(i_pwdata[PERIOD_W-1:0]) * PK_W'(RECIP_100);
                end
                REG_LIMIT:    r_cfg.limit       <= i_pwdata[LIMIT_W-1:0];
                REG_DEADBAND: r_cfg.deadband    <= i_pwdata[DEADBAND_W-1:0];
                REG_FLOOR:    r_cfg.speed_floor <= i_pwdata[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PERIOD:   o_prdata = APB_DATA_W'(r_cfg.period);
            REG_LIMIT:    o_prdata = APB_DATA_W'(r_cfg.limit);
            REG_DEADBAND: o_prdata = APB_DATA_W'(r_cfg.deadband);
            REG_FLOOR:    o_prdata = APB_DATA_W'(r_cfg.speed_floor);
            default:      o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/hbp_stall.sv @@
// Command clamp, shared stall counter update and stop latch.
module hbp_stall
    import hbp_pkg::*;
(
    input  t_cfg                      i_cfg,
    input  logic signed [CMD_W-1:0]   i_left_cmd,
    input  logic signed [CMD_W-1:0]   i_right_cmd,
    input  logic signed [SPEED_W-1:0] i_left_speed,
    input  logic signed [SPEED_W-1:0] i_right_speed,
    input  logic                      i_stop_request,
    input  logic [COUNT_W-1:0]        i_count,
    input  logic                      i_latched,
    output t_stall_next               o_next
);

    function automatic logic signed [DUTY_W-1:0] clamp_pct(input logic signed [CMD_W-1:0] v);
        logic signed [DUTY_W-1:0] r;
        if (v > 16'sd100)       r = 8'sd100;
        else if (v < -16'sd100) r = -8'sd100;
        else                    r = v[DUTY_W-1:0];
        return r;
    endfunction

    function automatic logic [PCT_W-1:0] mag_pct(input logic signed [DUTY_W-1:0] v);
        logic [DUTY_W-1:0] m;
        m = v[DUTY_W-1] ? DUTY_W'(-v) : DUTY_W'(v);
        return m[PCT_W-1:0];
    endfunction

    function automatic logic [SPEED_W-1:0] mag_speed(input logic signed [SPEED_W-1:0] v);
        return v[SPEED_W-1] ? SPEED_W'(-v) : SPEED_W'(v);
    endfunction

    logic signed [DUTY_W-1:0] w_lc, w_rc;
    logic                     w_l_stall, w_r_stall;
    logic [COUNT_W-1:0]       w_count_l, w_count_r;
    logic                     w_latch_0, w_latch_l, w_latch_r;

    assign w_lc = clamp_pct(i_left_cmd);
    assign w_rc = clamp_pct(i_right_cmd);

    assign w_l_stall = (mag_pct(w_lc) > i_cfg.deadband) &&
                       (mag_speed(i_left_speed) < SPEED_W'(i_cfg.speed_floor));
    assign w_r_stall = (mag_pct(w_rc) > i_cfg.deadband) &&
                       (mag_speed(i_right_speed) < SPEED_W'(i_cfg.speed_floor));

    // Left side updates the counter first; right side works on that result.
    assign w_latch_0 = i_latched || i_stop_request;

    assign w_count_l = !w_l_stall ? '0 :
                       (i_count == COUNT_MAX) ? i_count : i_count + 1'b1;
    assign w_latch_l = w_latch_0 || (w_l_stall && (w_count_l > COUNT_W'(i_cfg.limit)));

    assign w_count_r = !w_r_stall ? '0 :
                       (w_count_l == COUNT_MAX) ? w_count_l : w_count_l + 1'b1;
    assign w_latch_r = w_latch_l || (w_r_stall && (w_count_r > COUNT_W'(i_cfg.limit)));

    assign o_next.count      = w_count_r;
    assign o_next.latched    = w_latch_r;
    assign o_next.left_duty  = w_latch_r ? '0 : w_lc;
    assign o_next.right_duty = w_latch_r ? '0 : w_rc;

endmodule

@@ hw/rtl/hbp_side.sv @@
// Compare values of the two channels of one bridge side.
module hbp_side
    import hbp_pkg::*;
(
    input  t_cfg                     i_cfg,
    input  logic signed [DUTY_W-1:0] i_duty,
    output logic [PERIOD_W-1:0]      o_high,
    output logic [PERIOD_W-1:0]      o_low
);

    localparam int PROD_W = PK_W + PCT_W;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;

    logic [DUTY_W-1:0]   w_abs;
    logic [PCT_W-1:0]    w_off;
    logic [PROD_W-1:0]   w_prod;
    logic [Q_W-1:0]      w_q;
    logic [PERIOD_W-1:0] w_top;
    logic [PERIOD_W-1:0] w_cmp;

    assign w_abs  = i_duty[DUTY_W-1] ? DUTY_W'(-i_duty) : DUTY_W'(i_duty);
    assign w_off  = FULL_PCT - w_abs[PCT_W-1:0];
    // period*(100-|duty|)/100 by the precomputed reciprocal product.
    assign w_prod = PROD_W'(i_cfg.period_k) * PROD_W'(w_off);
    assign w_q    = w_prod[PROD_W-1:RECIP_SHIFT];
    assign w_top  = i_cfg.period - 1'b1;
    assign w_cmp  = (w_q >= Q_W'(i_cfg.period)) ? w_top : w_q[PERIOD_W-1:0];

    assign o_high = i_duty[DUTY_W-1] ? w_cmp : w_top;
    assign o_low  = i_duty[DUTY_W-1] ? w_top : w_cmp;

endmodule

@@ hw/rtl/hbridge_pwm_with_stall_cutoff.sv @@
// Top level of the dual H-bridge PWM driver with shared stall cutoff.
//
//   channel   direction  handshake               payload
//   s         in         i_s_tvalid/o_s_tready   tdata: cmds, speeds; tuser: stop_request
//   m         out        o_m_tvalid/i_m_tready   tdata: compares, duties; tuser: stopped
//   apb       in/out     psel/penable/pready     four configuration registers
//
// Each word is captured in the input register, and the clamp, stall update
// and compare arithmetic run from there into the result register. A new
// word is accepted in every cycle while the result is taken, so the
// sustained rate is then one word per cycle; the single stall counter and
// stop latch are updated as each word moves into the result register.
// Reset is synchronous and active low; it clears the valid flags, the
// stall counter, the stop latch and the configuration registers to their
// defaults. When the result is not taken the input register still accepts
// one more word, after which o_s_tready drops until the result moves on.
module hbridge_pwm_with_stall_cutoff
    import hbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // tdata from bit 0: left_cmd, right_cmd, left_speed, right_speed (16 bits each).
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // tuser bit 0: stop_request.
    input  logic                  i_s_tuser,
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // tdata from bit 0: left_high_compare, left_low_compare, right_high_compare,
    // right_low_compare (16 bits each), left_duty, right_duty (8 bits each).
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // tuser bit 0: stopped.
    output logic                  o_m_tuser,
    // Configuration port.
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    t_cfg w_cfg;

    hbp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // Input register and handshake.
    logic                 r_in_valid;
    logic [IN_DATA_W-1:0] r_in_data;
    logic                 r_in_stop;
    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                 r_out_stop;
    logic [COUNT_W-1:0]   r_stall_count;
    logic                 r_stop_latched;

    logic w_out_free, w_s_fire, w_advance;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_s_fire   = i_s_tvalid && o_s_tready;
    assign w_advance  = r_in_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_in_data <= i_s_tdata;
            r_in_stop <= i_s_tuser;
        end
    end

    // Stall counter, stop latch and duties for the word in the input register.
    t_stall_next w_next;

    hbp_stall u_stall (
        .i_cfg          (w_cfg),
        .i_left_cmd     (r_in_data[15:0]),
        .i_right_cmd    (r_in_data[31:16]),
        .i_left_speed   (r_in_data[47:32]),
        .i_right_speed  (r_in_data[63:48]),
        .i_stop_request (r_in_stop),
        .i_count        (r_stall_count),
        .i_latched      (r_stop_latched),
        .o_next         (w_next)
    );

    // Channel compares, one instance per bridge side sharing the period.
    logic [PERIOD_W-1:0] w_lh, w_ll, w_rh, w_rl;

    hbp_side u_side_left (
        .i_cfg  (w_cfg),
        .i_duty (w_next.left_duty),
        .o_high (w_lh),
        .o_low  (w_ll)
    );

    hbp_side u_side_right (
        .i_cfg  (w_cfg),
        .i_duty (w_next.right_duty),
        .o_high (w_rh),
        .o_low  (w_rl)
    );

    // State is committed only when the word moves into the result register,
    // so a stalled word is never counted twice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_count  <= '0;
            r_stop_latched <= 1'b0;
        end else if (w_advance) begin
            r_stall_count  <= w_next.count;
            r_stop_latched <= w_next.latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {w_next.right_duty, w_next.left_duty, w_rl, w_rh, w_ll, w_lh};
            r_out_stop <= w_next.latched;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_stop;

endmodule
